>>> rtl/bbr_pkg.sv
// ----------------------------------------------------------------------------
// bbr_pkg: shared types and constants of the 3x3 RGB box blur
// Sizes, pixel and window column types, sequencer states, register indexes
// and the reciprocal table used for the rounded mean.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bbr_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 4096;

    localparam int COL_W    = $clog2(MAX_WIDTH);    // column counter
    localparam int ROW_W    = $clog2(MAX_HEIGHT);   // row counter
    localparam int WCFG_W   = 11;                   // frame_width register
    localparam int HCFG_W   = 13;                   // frame_height register
    localparam int CFG_D_W  = 13;                   // widest register
    localparam int CFG_I_W  = 1;

    localparam logic [WCFG_W-1:0] WIDTH_RST  = WCFG_W'(1024);
    localparam logic [HCFG_W-1:0] HEIGHT_RST = HCFG_W'(768);

    localparam int CH_W     = 8;
    localparam int NCH      = 3;                    // [2] red, [1] green, [0] blue
    localparam int WIN      = 3;                    // window is WIN x WIN
    localparam int BANKS    = 4;                    // line store rows, by row mod 4
    localparam int BANK_W   = $clog2(BANKS);
    localparam int K_W      = $clog2(WIN);
    localparam int CCNT_W   = 2;                    // valid pixels in one column
    localparam int CNT_W    = 4;                    // valid pixels in the window
    localparam int COLSUM_W = CH_W + 2;
    localparam int TOT_W    = CH_W + 4;
    localparam int X_W      = TOT_W + 1;            // 2*sum + n
    localparam int RECIP_W  = 16;
    localparam int QSHIFT   = 16;
    localparam int PROD_W   = X_W + RECIP_W;

    typedef logic [NCH-1:0][CH_W-1:0] t_pix;

    typedef struct packed {
        t_pix [WIN-1:0]    pix;
        logic [CCNT_W-1:0] cnt;
    } t_col;

    typedef struct packed {
        logic [NCH-1:0][COLSUM_W-1:0] sum;
        logic [CCNT_W-1:0]            cnt;
    } t_colsum;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_FLUSH,
        ST_SUM,
        ST_MUL
    } t_state;

    typedef enum logic [CFG_I_W-1:0] {
        CFG_WIDTH  = 1'b0,
        CFG_HEIGHT = 1'b1
    } t_cfg_idx;

    typedef enum logic {
        OP_PUSH  = 1'b0,
        OP_DRAIN = 1'b1
    } t_op;

    // ceil(2^16 / 2n); exact floor for every 2*sum+n of a 3x3 window
    function automatic logic [RECIP_W-1:0] recip(input logic [CNT_W-1:0] n);
        logic [RECIP_W-1:0] m;
        case (n)
            CNT_W'(1): m = RECIP_W'(32768);
            CNT_W'(2): m = RECIP_W'(16384);
            CNT_W'(3): m = RECIP_W'(10923);
            CNT_W'(4): m = RECIP_W'(8192);
            CNT_W'(6): m = RECIP_W'(5462);
            CNT_W'(9): m = RECIP_W'(3641);
            default:   m = '0;
        endcase
        return m;
    endfunction

endpackage

>>> rtl/bbr_in_if.sv
// ----------------------------------------------------------------------------
// bbr_in_if: input item channel
// Valid/ready channel carrying the op code and one RGB pixel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface bbr_in_if;
    logic                     valid;
    logic                     ready;
    logic                     op;
    logic [bbr_pkg::CH_W-1:0] in_red;
    logic [bbr_pkg::CH_W-1:0] in_green;
    logic [bbr_pkg::CH_W-1:0] in_blue;

    modport source (output valid, output op, output in_red, output in_green,
                    output in_blue, input ready);
    modport sink   (input valid, input op, input in_red, input in_green,
                    input in_blue, output ready);
endinterface

>>> rtl/bbr_out_if.sv
// ----------------------------------------------------------------------------
// bbr_out_if: result item channel
// Valid/ready channel carrying one blurred pixel and the frame end flag.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface bbr_out_if;
    logic                     valid;
    logic                     ready;
    logic [bbr_pkg::CH_W-1:0] out_red;
    logic [bbr_pkg::CH_W-1:0] out_green;
    logic [bbr_pkg::CH_W-1:0] out_blue;
    logic                     frame_last;

    modport source (output valid, output out_red, output out_green,
                    output out_blue, output frame_last, input ready);
    modport sink   (input valid, input out_red, input out_green,
                    input out_blue, input frame_last, output ready);
endinterface

>>> rtl/bbr_line_bank.sv
// ----------------------------------------------------------------------------
// bbr_line_bank: one row of the line store
// Single write port, single read port, registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bbr_line_bank (
    input  logic                      i_clk,
    input  logic                      i_we,
    input  logic [bbr_pkg::COL_W-1:0] i_waddr,
    input  bbr_pkg::t_pix             i_wdata,
    input  logic [bbr_pkg::COL_W-1:0] i_raddr,
    output bbr_pkg::t_pix             o_rdata
);

    bbr_pkg::t_pix r_mem [bbr_pkg::MAX_WIDTH];
    bbr_pkg::t_pix r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/bbr_win_cell.sv
// ----------------------------------------------------------------------------
// bbr_win_cell: one column of the 3x3 window
// Holds three masked pixels and their valid count, hands them to the next
// cell on shift, and offers the column sum of each channel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bbr_win_cell (
    input  logic              i_clk,
    input  logic              i_shift,
    input  bbr_pkg::t_col     i_col,
    output bbr_pkg::t_col     o_col,
    output bbr_pkg::t_colsum  o_sum
);

    bbr_pkg::t_col r_col;

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_col <= i_col;
        end
    end

    always_comb begin
        for (int ch = 0; ch < bbr_pkg::NCH; ch++) begin
            o_sum.sum[ch] = bbr_pkg::COLSUM_W'(r_col.pix[0][ch])
                          + bbr_pkg::COLSUM_W'(r_col.pix[1][ch])
                          + bbr_pkg::COLSUM_W'(r_col.pix[2][ch]);
        end
        o_sum.cnt = r_col.cnt;
    end

    assign o_col = r_col;

endmodule

>>> rtl/box_blur_3x3_rgb.sv
// ----------------------------------------------------------------------------
// box_blur_3x3_rgb: 3x3 box blur over a raster-order RGB pixel stream
// An item that releases a result starts a job: 3 line store reads shifted
// through a 3-cell window, a sum stage, a multiply stage. The input is not
// ready until the job has loaded the output register; other items start no job.
// Reset (sync, active low): counters cleared, frame size 1024 x 768.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module box_blur_3x3_rgb (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    bbr_in_if.sink                      i_pix,
    bbr_out_if.source                   o_pix,
    input  logic                        i_cfg_we,
    input  logic [bbr_pkg::CFG_I_W-1:0] i_cfg_idx,
    input  logic [bbr_pkg::CFG_D_W-1:0] i_cfg_data
);

    localparam int CW = bbr_pkg::COL_W;
    localparam int RW = bbr_pkg::ROW_W;

    // configuration
    logic [bbr_pkg::WCFG_W-1:0] r_cfg_w;
    logic [bbr_pkg::HCFG_W-1:0] r_cfg_h;
    logic [bbr_pkg::WCFG_W-1:0] w_eff;
    logic [bbr_pkg::HCFG_W-1:0] h_eff;

    // frame position
    logic [CW-1:0] r_ic, n_ic, r_oc, n_oc;
    logic [RW-1:0] r_ir, n_ir, r_or, n_or;
    logic          r_done, n_done;

    // sequencer
    bbr_pkg::t_state           r_state, n_state;
    logic [bbr_pkg::K_W-1:0]   r_k, n_k;
    logic [CW-1:0]             r_job_c;
    logic [RW-1:0]             r_job_r;
    logic                      r_job_last;
    logic                      r_rd_vld, r_rd_colv;

    // arithmetic
    logic [bbr_pkg::X_W-1:0]     r_x [bbr_pkg::NCH];
    logic [bbr_pkg::RECIP_W-1:0] r_m;
    logic [bbr_pkg::X_W-1:0]     x   [bbr_pkg::NCH];
    logic [bbr_pkg::CNT_W-1:0]   n_pix;
    logic [bbr_pkg::PROD_W-1:0]  prod [bbr_pkg::NCH];

    // output register
    bbr_pkg::t_pix r_out_pix;
    logic          r_out_last;
    logic          r_out_vld, n_out_vld;
    logic          load_out;

    // handshake and decode
    logic accept, is_drain, push_ok, drain_ok, push_emit, emit, out_last;
    logic ic_wrap, ir_wrap;

    // line store
    bbr_pkg::t_pix              px_in;
    bbr_pkg::t_pix              rd_data [bbr_pkg::BANKS];
    logic [CW:0]                rd_col;
    logic                       rd_colv;
    logic [bbr_pkg::BANK_W-1:0] b_top, b_mid, b_bot;
    logic                       top_v, bot_v;

    // window
    bbr_pkg::t_col    col_in;
    bbr_pkg::t_col    col_q [bbr_pkg::WIN];
    bbr_pkg::t_colsum col_s [bbr_pkg::WIN];

    // ---------------------------------------------------------------- config
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w <= bbr_pkg::WIDTH_RST;
            r_cfg_h <= bbr_pkg::HEIGHT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                bbr_pkg::CFG_WIDTH:  r_cfg_w <= i_cfg_data[bbr_pkg::WCFG_W-1:0];
                bbr_pkg::CFG_HEIGHT: r_cfg_h <= i_cfg_data[bbr_pkg::HCFG_W-1:0];
                default: ;
            endcase
        end
    end

    // out-of-range sizes are clamped
    assign w_eff = (r_cfg_w == '0) ? bbr_pkg::WCFG_W'(1) :
                   (r_cfg_w > bbr_pkg::WCFG_W'(bbr_pkg::MAX_WIDTH)) ?
                   bbr_pkg::WCFG_W'(bbr_pkg::MAX_WIDTH) : r_cfg_w;
    assign h_eff = (r_cfg_h == '0) ? bbr_pkg::HCFG_W'(1) :
                   (r_cfg_h > bbr_pkg::HCFG_W'(bbr_pkg::MAX_HEIGHT)) ?
                   bbr_pkg::HCFG_W'(bbr_pkg::MAX_HEIGHT) : r_cfg_h;

    // ---------------------------------------------------------------- decode
    assign i_pix.ready = (r_state == bbr_pkg::ST_IDLE);
    assign accept      = i_pix.valid && i_pix.ready;
    assign is_drain    = (i_pix.op == bbr_pkg::OP_DRAIN);
    assign push_ok     = !is_drain && !r_done;
    assign drain_ok    = is_drain && r_done;

    assign ic_wrap   = (bbr_pkg::WCFG_W'(r_ic) + bbr_pkg::WCFG_W'(1)) >= w_eff;
    assign ir_wrap   = (bbr_pkg::HCFG_W'(r_ir) + bbr_pkg::HCFG_W'(1)) >= h_eff;
    // pixel index >= width + 1
    assign push_emit = (r_ir >= RW'(2)) || ((r_ir == RW'(1)) && (r_ic != '0));
    assign emit      = accept && (drain_ok || (push_ok && push_emit));
    assign out_last  = ((bbr_pkg::HCFG_W'(r_or) + bbr_pkg::HCFG_W'(1)) >= h_eff) &&
                       ((bbr_pkg::WCFG_W'(r_oc) + bbr_pkg::WCFG_W'(1)) >= w_eff);

    // ------------------------------------------------------------ sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= bbr_pkg::ST_IDLE;
            r_k       <= '0;
            r_ic      <= '0;
            r_ir      <= '0;
            r_oc      <= '0;
            r_or      <= '0;
            r_done    <= 1'b0;
            r_out_vld <= 1'b0;
            r_rd_vld  <= 1'b0;
            r_rd_colv <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_k       <= n_k;
            r_ic      <= n_ic;
            r_ir      <= n_ir;
            r_oc      <= n_oc;
            r_or      <= n_or;
            r_done    <= n_done;
            r_out_vld <= n_out_vld;
            r_rd_vld  <= (r_state == bbr_pkg::ST_READ);
            r_rd_colv <= rd_colv;
        end
    end

    always_comb begin
        n_state   = r_state;
        n_k       = r_k;
        n_ic      = r_ic;
        n_ir      = r_ir;
        n_oc      = r_oc;
        n_or      = r_or;
        n_done    = r_done;
        n_out_vld = r_out_vld;
        load_out  = 1'b0;

        if (r_out_vld && o_pix.ready) begin
            n_out_vld = 1'b0;
        end

        unique case (r_state)
            bbr_pkg::ST_IDLE: begin
                if (emit) begin
                    n_state = bbr_pkg::ST_READ;
                    n_k     = '0;
                end
            end
            bbr_pkg::ST_READ: begin
                n_k = r_k + bbr_pkg::K_W'(1);
                if (r_k == bbr_pkg::K_W'(bbr_pkg::WIN - 1)) begin
                    n_state = bbr_pkg::ST_FLUSH;
                end
            end
            bbr_pkg::ST_FLUSH: n_state = bbr_pkg::ST_SUM;
            bbr_pkg::ST_SUM:   n_state = bbr_pkg::ST_MUL;
            bbr_pkg::ST_MUL: begin
                if (!r_out_vld || o_pix.ready) begin
                    n_state   = bbr_pkg::ST_IDLE;
                    n_out_vld = 1'b1;
                    load_out  = 1'b1;
                end
            end
            default: n_state = bbr_pkg::ST_IDLE;
        endcase

        if (i_cfg_we) begin
            n_ic   = '0;
            n_ir   = '0;
            n_oc   = '0;
            n_or   = '0;
            n_done = 1'b0;
        end else if (accept) begin
            if (push_ok) begin
                if (ic_wrap) begin
                    n_ic = '0;
                    if (ir_wrap) begin
                        n_done = 1'b1;
                        n_ir   = '0;
                    end else begin
                        n_ir = r_ir + RW'(1);
                    end
                end else begin
                    n_ic = r_ic + CW'(1);
                end
            end
            if (emit) begin
                if (out_last) begin
                    // frame complete: start over
                    n_ic   = '0;
                    n_ir   = '0;
                    n_oc   = '0;
                    n_or   = '0;
                    n_done = 1'b0;
                end else if ((bbr_pkg::WCFG_W'(r_oc) + bbr_pkg::WCFG_W'(1)) >= w_eff) begin
                    n_oc = '0;
                    n_or = r_or + RW'(1);
                end else begin
                    n_oc = r_oc + CW'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_job_c    <= r_oc;
            r_job_r    <= r_or;
            r_job_last <= out_last;
        end
    end

    // ------------------------------------------------------------ line store
    assign px_in = {i_pix.in_red, i_pix.in_green, i_pix.in_blue};

    // columns c-1, c, c+1 are read on consecutive cycles
    assign rd_col = {1'b0, r_job_c} + (CW + 1)'(r_k) - (CW + 1)'(1);

    always_comb begin
        case (r_k)
            bbr_pkg::K_W'(0): rd_colv = (r_job_c != '0);
            bbr_pkg::K_W'(1): rd_colv = 1'b1;
            bbr_pkg::K_W'(2): rd_colv = (bbr_pkg::WCFG_W'(r_job_c) + bbr_pkg::WCFG_W'(1))
                                        < w_eff;
            default:          rd_colv = 1'b0;
        endcase
    end

    for (genvar b = 0; b < bbr_pkg::BANKS; b++) begin : g_bank
        bbr_line_bank u_bank (
            .i_clk   (i_clk),
            .i_we    (accept && push_ok &&
                      (r_ir[bbr_pkg::BANK_W-1:0] == bbr_pkg::BANK_W'(b))),
            .i_waddr (r_ic),
            .i_wdata (px_in),
            .i_raddr (rd_col[CW-1:0]),
            .o_rdata (rd_data[b])
        );
    end

    // ---------------------------------------------------------------- window
    assign b_mid = r_job_r[bbr_pkg::BANK_W-1:0];
    assign b_top = b_mid - bbr_pkg::BANK_W'(1);
    assign b_bot = b_mid + bbr_pkg::BANK_W'(1);
    assign top_v = (r_job_r != '0);
    assign bot_v = (bbr_pkg::HCFG_W'(r_job_r) + bbr_pkg::HCFG_W'(1)) < h_eff;

    always_comb begin
        col_in.pix[0] = (r_rd_colv && top_v) ? rd_data[b_top] : '0;
        col_in.pix[1] = r_rd_colv            ? rd_data[b_mid] : '0;
        col_in.pix[2] = (r_rd_colv && bot_v) ? rd_data[b_bot] : '0;
        col_in.cnt    = r_rd_colv ? (bbr_pkg::CCNT_W'(1) + bbr_pkg::CCNT_W'(top_v)
                                     + bbr_pkg::CCNT_W'(bot_v)) : '0;
    end

    for (genvar j = 0; j < bbr_pkg::WIN; j++) begin : g_cell
        bbr_win_cell u_cell (
            .i_clk   (i_clk),
            .i_shift (r_rd_vld),
            .i_col   ((j == 0) ? col_in : col_q[(j == 0) ? 0 : j - 1]),
            .o_col   (col_q[j]),
            .o_sum   (col_s[j])
        );
    end

    // ------------------------------------------------------------ arithmetic
    always_comb begin
        n_pix = bbr_pkg::CNT_W'(col_s[0].cnt) + bbr_pkg::CNT_W'(col_s[1].cnt)
              + bbr_pkg::CNT_W'(col_s[2].cnt);
        for (int ch = 0; ch < bbr_pkg::NCH; ch++) begin
            x[ch] = {bbr_pkg::TOT_W'(col_s[0].sum[ch]) + bbr_pkg::TOT_W'(col_s[1].sum[ch])
                     + bbr_pkg::TOT_W'(col_s[2].sum[ch]), 1'b0} + bbr_pkg::X_W'(n_pix);
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == bbr_pkg::ST_SUM) begin
            r_x <= x;
            r_m <= bbr_pkg::recip(n_pix);
        end
    end

    // (2*sum + n) / (2n) by reciprocal multiply
    always_comb begin
        for (int ch = 0; ch < bbr_pkg::NCH; ch++) begin
            prod[ch] = bbr_pkg::PROD_W'(r_x[ch]) * bbr_pkg::PROD_W'(r_m);
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            for (int ch = 0; ch < bbr_pkg::NCH; ch++) begin
                r_out_pix[ch] <= prod[ch][bbr_pkg::QSHIFT +: bbr_pkg::CH_W];
            end
            r_out_last <= r_job_last;
        end
    end

    assign o_pix.valid      = r_out_vld;
    assign o_pix.out_red    = r_out_pix[2];
    assign o_pix.out_green  = r_out_pix[1];
    assign o_pix.out_blue   = r_out_pix[0];
    assign o_pix.frame_last = r_out_last;

    // ------------------------------------------------------------ assertions
    a_job_timing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit |-> ##6 (r_state == bbr_pkg::ST_MUL))
        else $error("released item did not reach the multiply stage on time");

    a_center_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == bbr_pkg::ST_MUL) |-> (r_m != '0))
        else $error("window holds no valid pixel count");

    a_done_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> ((r_ic == '0) && (r_ir == '0)))
        else $error("input position moved after frame end");

    a_out_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_vld) |-> ($past(r_state) == bbr_pkg::ST_MUL))
        else $error("output loaded outside the multiply stage");

endmodule
